// ----- sv/rss_pkg.sv -----
package rss_pkg;

	localparam int MAX_ENTRIES_DEF = 32;
	localparam int MAX_REGS_DEF    = 64;
	localparam int CYCLE_BITS_DEF  = 32;

	localparam int FW = 6; // count fields of the result
	localparam int RW = 7; // register numbers and station bounds
	localparam int NG = 3; // firing groups

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_DIV = 2'd1;
	localparam logic [1:0] OP_MEM = 2'd2;

	localparam logic [2:0] CFG_RS_MODE   = 3'd0;
	localparam logic [2:0] CFG_UNIFIED   = 3'd1;
	localparam logic [2:0] CFG_ADD       = 3'd2;
	localparam logic [2:0] CFG_DIV       = 3'd3;
	localparam logic [2:0] CFG_MEM       = 3'd4;
	localparam logic [2:0] CFG_REG_COUNT = 3'd5;

	localparam logic [4:0] LAT_ADD = 5'd2;
	localparam logic [4:0] LAT_DIV = 5'd15;
	localparam logic [4:0] LAT_MEM = 5'd20;

	function automatic logic [4:0] lat_of(input logic [1:0] op);
		case (op)
			OP_DIV:  lat_of = LAT_DIV;
			OP_MEM:  lat_of = LAT_MEM;
			default: lat_of = LAT_ADD;
		endcase
	endfunction

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic          mode;
		logic [RW-1:0] ilo;
		logic [RW-1:0] ihi;
		logic [RW-1:0] a_hi;
		logic [RW-1:0] d_hi;
		logic [RW-1:0] m_hi;
		logic [RW-1:0] qa;
		logic [RW-1:0] qb;
		logic [RW-1:0] qd;
		logic          qd_ok;
		logic [1:0]    op;
		logic          tick;
		logic          issue;
		logic          fire;
	} ctl_t;

endpackage

// ----- sv/reservation_station_scheduler.sv -----
// Issue scheduler with reservation stations and renaming, timing only.
// Input channel in_valid/in_ready carries one request: req_type 0 issues an
// operation (op_kind, dest_reg, src_a_reg, src_b_reg), req_type 1 is a tick.
// Every request returns exactly one result on out_valid/out_ready.
// Station sizes and mode come through cfg_valid/cfg_ready with cfg_index and cfg_data;
// write them only while no request is in flight (not enforced here); cfg_ready is always 1.
// Entries are a chain of cells; a scan packet walks one cell per cycle to find
// the free slot, the source producers and the oldest ready entry per group.
// After an issue is accepted the sequencer walks ST_PASS over the cell chain, then
// ST_APPLY and ST_DONE before out_valid rises; a tick passes ST_TICK first.
// One request is worked on at a time; a new one is accepted once the previous
// one has finished, even if its result still waits in the output register.
// If the receiver stalls with a result already waiting, the next finished
// result holds in the sequencer until the output register frees.
// Reset empties every entry and the rename links, sets the cycle count to one
// and the registers to their reset values.
module reservation_station_scheduler #(
	parameter int MAX_ENTRIES = rss_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_REGS    = rss_pkg::MAX_REGS_DEF,
	parameter int CYCLE_BITS  = rss_pkg::CYCLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  req_type,
	input  logic [1:0]            op_kind,
	input  logic [rss_pkg::RW-1:0] dest_reg,
	input  logic [rss_pkg::RW-1:0] src_a_reg,
	input  logic [rss_pkg::RW-1:0] src_b_reg,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  issue_accepted,
	output logic [1:0]            fired_count,
	output logic [rss_pkg::FW-1:0] completed_count,
	output logic [rss_pkg::FW-1:0] active_add,
	output logic [rss_pkg::FW-1:0] active_div,
	output logic [rss_pkg::FW-1:0] active_mem,
	output logic                  drained,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [rss_pkg::RW-1:0] cfg_data
);
	import rss_pkg::*;

	localparam int N   = MAX_ENTRIES;
	localparam int IW  = (N > 1) ? $clog2(N) : 1;
	localparam int CNW = $clog2(N + 1);
	localparam int PW  = (N > 1) ? $clog2(N) : 1;
	localparam logic [7:0] NMAX = 8'(N);
	localparam logic [7:0] RMAX = 8'(MAX_REGS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_TICK  = 3'd1;
	localparam logic [2:0] ST_PASS  = 3'd2;
	localparam logic [2:0] ST_APPLY = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]      st_q;
	logic [PW-1:0]   pass_q;
	logic            typ_q;
	logic [1:0]      op_q;
	logic [RW-1:0]   dest_q, sa_q, sb_q;
	logic            mode_q;
	logic [5:0]      uni_q, add_q, div_q, mem_q;
	logic [RW-1:0]   regc_q;
	logic [CYCLE_BITS-1:0] cyc_q;

	logic            res_acc_q;
	logic [1:0]      res_fired_q;
	logic [FW-1:0]   res_done_q, res_add_q, res_div_q, res_mem_q;

	ctl_t            ctl;
	logic [7:0]      a_b, d_b, m_b, u_b, regmax;
	logic [N-1:0]    done_vec, busy_vec;

	logic [N:0]                  c_free, c_ah, c_bh;
	logic [N:0][IW-1:0]          c_fidx, c_ai, c_bi;
	logic [N:0][2:0]             c_pv;
	logic [N:0][2:0][IW-1:0]     c_pidx;
	logic [N:0][2:0][CYCLE_BITS-1:0] c_pst;
	logic [N:0][2:0][1:0]        c_pop;
	logic [N:0][2:0][CNW-1:0]    c_cnt;
	logic [N:0][CNW-1:0]         c_dn;

	logic [2:0][7:0] act_sum;
	logic [1:0]      fired_n;

	function automatic logic [7:0] clamp(input logic [7:0] v);
		clamp = (v > NMAX) ? NMAX : v;
	endfunction

	function automatic logic reg_ok(input logic [RW-1:0] r, input logic [7:0] mx);
		reg_ok = (r != '0) && ({1'b0, r} <= mx);
	endfunction

	assign cfg_ready = 1'b1;
	assign in_ready  = (st_q == ST_IDLE);

	always_comb begin
		a_b    = clamp({2'b0, add_q});
		d_b    = clamp(a_b + {2'b0, div_q});
		m_b    = clamp(d_b + {2'b0, mem_q});
		u_b    = clamp({2'b0, uni_q});
		regmax = ({1'b0, regc_q} > RMAX) ? RMAX : {1'b0, regc_q};

		ctl.mode = mode_q;
		ctl.a_hi = a_b[RW-1:0];
		ctl.d_hi = d_b[RW-1:0];
		ctl.m_hi = m_b[RW-1:0];
		ctl.ilo  = '0;
		ctl.ihi  = '0;
		if (mode_q) begin
			ctl.ihi = (op_q == 2'd3) ? '0 : u_b[RW-1:0];
		end else begin
			case (op_q)
				OP_ADD: ctl.ihi = a_b[RW-1:0];
				OP_DIV: begin
					ctl.ilo = a_b[RW-1:0];
					ctl.ihi = d_b[RW-1:0];
				end
				OP_MEM: begin
					ctl.ilo = d_b[RW-1:0];
					ctl.ihi = m_b[RW-1:0];
				end
				default: ctl.ihi = '0;
			endcase
		end
		// register 0 never names a producer
		ctl.qa    = reg_ok(sa_q, regmax) ? sa_q : '0;
		ctl.qb    = reg_ok(sb_q, regmax) ? sb_q : '0;
		ctl.qd    = dest_q;
		ctl.qd_ok = reg_ok(dest_q, regmax);
		ctl.op    = op_q;
		ctl.tick  = (st_q == ST_TICK);
		ctl.issue = (st_q == ST_APPLY) && !typ_q;
		ctl.fire  = (st_q == ST_APPLY) && typ_q;
	end

	assign c_free[0] = 1'b0;
	assign c_fidx[0] = '0;
	assign c_ah[0]   = 1'b0;
	assign c_ai[0]   = '0;
	assign c_bh[0]   = 1'b0;
	assign c_bi[0]   = '0;
	assign c_pv[0]   = '0;
	assign c_pidx[0] = '0;
	assign c_pst[0]  = '0;
	assign c_pop[0]  = '0;
	assign c_cnt[0]  = '0;
	assign c_dn[0]   = '0;

	for (genvar k = 0; k < N; k++) begin : g_cell
		rss_cell #(
			.N(N), .CB(CYCLE_BITS), .IW(IW), .CNW(CNW), .IDX(k)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl), .cyc(cyc_q), .done_vec(done_vec),
			.ap_free(c_free[N]), .ap_idx(c_fidx[N]),
			.ap_a_hit(c_ah[N]), .ap_a_idx(c_ai[N]),
			.ap_b_hit(c_bh[N]), .ap_b_idx(c_bi[N]),
			.ap_pv(c_pv[N]), .ap_pidx(c_pidx[N]),
			.i_free(c_free[k]), .i_fidx(c_fidx[k]), .i_ah(c_ah[k]), .i_ai(c_ai[k]),
			.i_bh(c_bh[k]), .i_bi(c_bi[k]), .i_pv(c_pv[k]), .i_pidx(c_pidx[k]),
			.i_pst(c_pst[k]), .i_pop(c_pop[k]), .i_cnt(c_cnt[k]), .i_dn(c_dn[k]),
			.o_free(c_free[k+1]), .o_fidx(c_fidx[k+1]), .o_ah(c_ah[k+1]),
			.o_ai(c_ai[k+1]), .o_bh(c_bh[k+1]), .o_bi(c_bi[k+1]),
			.o_pv(c_pv[k+1]), .o_pidx(c_pidx[k+1]), .o_pst(c_pst[k+1]),
			.o_pop(c_pop[k+1]), .o_cnt(c_cnt[k+1]), .o_dn(c_dn[k+1]),
			.busy(busy_vec[k]), .done(done_vec[k])
		);
	end

	always_comb begin
		fired_n = 2'(c_pv[N][0]) + 2'(c_pv[N][1]) + 2'(c_pv[N][2]);
		for (int o = 0; o < NG; o++) begin
			act_sum[o] = 8'(c_cnt[N][o]);
			for (int g = 0; g < NG; g++)
				if (c_pv[N][g] && c_pop[N][g] == 2'(o))
					act_sum[o] = act_sum[o] + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			uni_q  <= '0;
			add_q  <= '0;
			div_q  <= '0;
			mem_q  <= '0;
			regc_q <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_RS_MODE:   mode_q <= cfg_data[0];
				CFG_UNIFIED:   uni_q  <= cfg_data[5:0];
				CFG_ADD:       add_q  <= cfg_data[5:0];
				CFG_DIV:       div_q  <= cfg_data[5:0];
				CFG_MEM:       mem_q  <= cfg_data[5:0];
				CFG_REG_COUNT: regc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			typ_q  <= req_type;
			op_q   <= op_kind;
			dest_q <= dest_reg;
			sa_q   <= src_a_reg;
			sb_q   <= src_b_reg;
		end
		if (st_q == ST_APPLY) begin
			if (typ_q) begin
				res_acc_q   <= 1'b0;
				res_fired_q <= fired_n;
				res_done_q  <= FW'(c_dn[N]);
				res_add_q   <= act_sum[0][FW-1:0];
				res_div_q   <= act_sum[1][FW-1:0];
				res_mem_q   <= act_sum[2][FW-1:0];
			end else begin
				res_acc_q   <= c_free[N];
				res_fired_q <= '0;
				res_done_q  <= '0;
				res_add_q   <= active_add;
				res_div_q   <= active_div;
				res_mem_q   <= active_mem;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q            <= ST_IDLE;
			pass_q          <= '0;
			cyc_q           <= CYCLE_BITS'(1);
			out_valid       <= 1'b0;
			issue_accepted  <= 1'b0;
			fired_count     <= '0;
			completed_count <= '0;
			active_add      <= '0;
			active_div      <= '0;
			active_mem      <= '0;
			drained         <= 1'b1;
		end else begin
			if (st_q == ST_DONE && (!out_valid || out_ready))
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						pass_q <= '0;
						st_q   <= req_type ? ST_TICK : ST_PASS;
					end
				end
				ST_TICK: begin
					cyc_q <= cyc_q + CYCLE_BITS'(1);
					st_q  <= ST_PASS;
				end
				ST_PASS: begin
					pass_q <= pass_q + PW'(1);
					if (pass_q == PW'(N - 1))
						st_q <= ST_APPLY;
				end
				ST_APPLY: st_q <= ST_DONE;
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						issue_accepted  <= res_acc_q;
						fired_count     <= res_fired_q;
						completed_count <= res_done_q;
						active_add      <= res_add_q;
						active_div      <= res_div_q;
						active_mem      <= res_mem_q;
						drained         <= ~|busy_vec;
						st_q            <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/rss_cell.sv -----
module rss_cell #(
	parameter int N   = 32,
	parameter int CB  = 32,
	parameter int IW  = (N > 1) ? $clog2(N) : 1,
	parameter int CNW = $clog2(N + 1),
	parameter int IDX = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rss_pkg::ctl_t                ctl,
	input  logic [CB-1:0]                cyc,
	input  logic [N-1:0]                 done_vec,
	input  logic                         ap_free,
	input  logic [IW-1:0]                ap_idx,
	input  logic                         ap_a_hit,
	input  logic [IW-1:0]                ap_a_idx,
	input  logic                         ap_b_hit,
	input  logic [IW-1:0]                ap_b_idx,
	input  logic [2:0]                   ap_pv,
	input  logic [2:0][IW-1:0]           ap_pidx,
	input  logic                         i_free,
	input  logic [IW-1:0]                i_fidx,
	input  logic                         i_ah,
	input  logic [IW-1:0]                i_ai,
	input  logic                         i_bh,
	input  logic [IW-1:0]                i_bi,
	input  logic [2:0]                   i_pv,
	input  logic [2:0][IW-1:0]           i_pidx,
	input  logic [2:0][CB-1:0]           i_pst,
	input  logic [2:0][1:0]              i_pop,
	input  logic [2:0][CNW-1:0]          i_cnt,
	input  logic [CNW-1:0]               i_dn,
	output logic                         o_free,
	output logic [IW-1:0]                o_fidx,
	output logic                         o_ah,
	output logic [IW-1:0]                o_ai,
	output logic                         o_bh,
	output logic [IW-1:0]                o_bi,
	output logic [2:0]                   o_pv,
	output logic [2:0][IW-1:0]           o_pidx,
	output logic [2:0][CB-1:0]           o_pst,
	output logic [2:0][1:0]              o_pop,
	output logic [2:0][CNW-1:0]          o_cnt,
	output logic [CNW-1:0]               o_dn,
	output logic                         busy,
	output logic                         done
);
	import rss_pkg::*;

	localparam logic [RW-1:0] ME   = RW'(IDX);
	localparam logic [IW-1:0] ME_I = IW'(IDX);

	logic          busy_q, exec_q, rn_q, done_q;
	logic [1:0]    op_q;
	logic [RW-1:0] dest_q;
	logic          ardy_q, brdy_q;
	logic [IW-1:0] atag_q, btag_q;
	logic [CB-1:0] stamp_q;
	logic [4:0]    cd_q;

	logic [1:0]    grp;
	logic          cand;
	logic          n_free, n_ah, n_bh;
	logic [IW-1:0] n_fidx, n_ai, n_bi;
	logic [2:0]    n_pv;
	logic [2:0][IW-1:0]  n_pidx;
	logic [2:0][CB-1:0]  n_pst;
	logic [2:0][1:0]     n_pop;
	logic [2:0][CNW-1:0] n_cnt;
	logic [CNW-1:0]      n_dn;
	logic                fire_me;

	assign busy = busy_q;
	assign done = busy_q && exec_q && (cd_q == 5'd1);

	always_comb begin
		if (ctl.mode)
			grp = op_q;
		else if (ME < ctl.a_hi)
			grp = 2'd0;
		else if (ME < ctl.d_hi)
			grp = 2'd1;
		else if (ME < ctl.m_hi)
			grp = 2'd2;
		else
			grp = 2'd3;
		cand = busy_q && !exec_q && ardy_q && brdy_q;

		n_free = i_free;
		n_fidx = i_fidx;
		if (!i_free && !busy_q && ME >= ctl.ilo && ME < ctl.ihi) begin
			n_free = 1'b1;
			n_fidx = ME_I;
		end
		// current producer lookup for the two sources
		n_ah = i_ah;
		n_ai = i_ai;
		if (busy_q && rn_q && dest_q == ctl.qa) begin
			n_ah = 1'b1;
			n_ai = ME_I;
		end
		n_bh = i_bh;
		n_bi = i_bi;
		if (busy_q && rn_q && dest_q == ctl.qb) begin
			n_bh = 1'b1;
			n_bi = ME_I;
		end

		n_pv   = i_pv;
		n_pidx = i_pidx;
		n_pst  = i_pst;
		n_pop  = i_pop;
		n_cnt  = i_cnt;
		for (int g = 0; g < NG; g++) begin
			if (cand && grp == 2'(g) && (!i_pv[g] || stamp_q < i_pst[g])) begin
				n_pv[g]   = 1'b1;
				n_pidx[g] = ME_I;
				n_pst[g]  = stamp_q;
				n_pop[g]  = op_q;
			end
			if (busy_q && exec_q && op_q == 2'(g))
				n_cnt[g] = i_cnt[g] + CNW'(1);
		end
		n_dn = i_dn + CNW'(done_q);

		fire_me = 1'b0;
		for (int g = 0; g < NG; g++)
			if (ap_pv[g] && ap_pidx[g] == ME_I)
				fire_me = 1'b1;
	end

	always_ff @(posedge clk) begin
		o_free <= n_free;
		o_fidx <= n_fidx;
		o_ah   <= n_ah;
		o_ai   <= n_ai;
		o_bh   <= n_bh;
		o_bi   <= n_bi;
		o_pv   <= n_pv;
		o_pidx <= n_pidx;
		o_pst  <= n_pst;
		o_pop  <= n_pop;
		o_cnt  <= n_cnt;
		o_dn   <= n_dn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			exec_q <= 1'b0;
			rn_q   <= 1'b0;
			done_q <= 1'b0;
		end else if (ctl.tick) begin
			done_q <= done;
			if (done) begin
				busy_q <= 1'b0;
				exec_q <= 1'b0;
				rn_q   <= 1'b0;
			end else begin
				if (exec_q)
					cd_q <= cd_q - 5'd1;
				if (busy_q && !ardy_q && done_vec[atag_q])
					ardy_q <= 1'b1;
				if (busy_q && !brdy_q && done_vec[btag_q])
					brdy_q <= 1'b1;
			end
		end else if (ctl.issue) begin
			if (ap_free && ap_idx == ME_I) begin
				busy_q  <= 1'b1;
				exec_q  <= 1'b0;
				rn_q    <= ctl.qd_ok;
				op_q    <= ctl.op;
				dest_q  <= ctl.qd;
				ardy_q  <= !ap_a_hit;
				atag_q  <= ap_a_idx;
				brdy_q  <= !ap_b_hit;
				btag_q  <= ap_b_idx;
				stamp_q <= cyc;
			end else if (ap_free && ctl.qd_ok && dest_q == ctl.qd) begin
				rn_q <= 1'b0;
			end
		end else if (ctl.fire && fire_me) begin
			exec_q <= 1'b1;
			cd_q   <= lat_of(op_q);
		end
	end

endmodule

// ----- sv/rss_chk.sv -----
module rss_chk (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   req_type,
	input logic [1:0]             op_kind,
	input logic [rss_pkg::RW-1:0] dest_reg,
	input logic [rss_pkg::RW-1:0] src_a_reg,
	input logic [rss_pkg::RW-1:0] src_b_reg,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic                   issue_accepted,
	input logic [1:0]             fired_count,
	input logic [rss_pkg::FW-1:0] completed_count,
	input logic [rss_pkg::FW-1:0] active_add,
	input logic [rss_pkg::FW-1:0] active_div,
	input logic [rss_pkg::FW-1:0] active_mem,
	input logic                   drained,
	input logic                   cfg_valid,
	input logic                   cfg_ready,
	input logic [2:0]             cfg_index,
	input logic [rss_pkg::RW-1:0] cfg_data
);

	// a waiting result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(issue_accepted)
			&& $stable(fired_count) && $stable(completed_count) && $stable(drained))
		else $error("stalled result changed");

	// one transaction in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while busy");

	// an accepted issue neither fires nor completes anything
	a_issue_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && issue_accepted |-> fired_count == '0 && completed_count == '0)
		else $error("issue result shows tick activity");

	// nothing executes once every entry has drained
	a_drained_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drained |-> active_add == '0 && active_div == '0
			&& active_mem == '0 && !issue_accepted)
		else $error("drained with work outstanding");

endmodule

bind reservation_station_scheduler rss_chk u_rss_chk (.*);

// ----- dv/reservation_station_scheduler_tb.sv -----
module reservation_station_scheduler_tb;
	import rss_pkg::*;

	localparam int NENT = 32;
	localparam int NREG = 64;
	localparam int SETTLE = NENT + 8;

	typedef struct packed {
		logic       accepted;
		logic [1:0] fired;
		logic [5:0] completed;
		logic [5:0] act_add;
		logic [5:0] act_div;
		logic [5:0] act_mem;
		logic       drained;
	} sched_result_t;

	typedef struct packed {
		logic          rt;
		logic [1:0]    op;
		logic [6:0]    dst;
		logic [6:0]    sa;
		logic [6:0]    sb;
		logic          typed;
		sched_result_t res;
	} stim_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic req_type = 0;
	logic [1:0] op_kind = 0;
	logic [6:0] dest_reg = 0;
	logic [6:0] src_a_reg = 0;
	logic [6:0] src_b_reg = 0;
	logic out_valid;
	logic out_ready = 0;
	logic issue_accepted;
	logic [1:0] fired_count;
	logic [5:0] completed_count, active_add, active_div, active_mem;
	logic drained;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = 0;
	logic [6:0] cfg_data = 0;

	always #5 clk = ~clk;

	reservation_station_scheduler DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .op_kind(op_kind), .dest_reg(dest_reg),
		.src_a_reg(src_a_reg), .src_b_reg(src_b_reg),
		.out_valid(out_valid), .out_ready(out_ready),
		.issue_accepted(issue_accepted), .fired_count(fired_count),
		.completed_count(completed_count), .active_add(active_add),
		.active_div(active_div), .active_mem(active_mem), .drained(drained),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// scheduler shadow state
	logic        sh_mode;
	logic [5:0]  sh_uni, sh_add, sh_div, sh_mem;
	logic [6:0]  sh_regs;
	bit          ent_busy [NENT];
	bit          ent_exec [NENT];
	logic [1:0]  ent_op [NENT];
	logic [5:0]  ent_tag_a [NENT];
	logic [5:0]  ent_tag_b [NENT];
	bit          ent_rdy_a [NENT];
	bit          ent_rdy_b [NENT];
	logic [31:0] ent_issued_at [NENT];
	logic [31:0] ent_started_at [NENT];
	logic [5:0]  producer_of [NREG];
	logic [31:0] cyc;
	logic [31:0] n_issued, n_retired;

	sched_result_t pending_results[$];
	int  fail_count = 0;
	bit  no_idle = 0;
	bit  hold_req = 0;

	function automatic int clamp_ent(int v);
		return (v > NENT) ? NENT : v;
	endfunction

	function automatic int op_latency(logic [1:0] op);
		case (op)
			OP_DIV:  return LAT_DIV;
			OP_MEM:  return LAT_MEM;
			default: return LAT_ADD;
		endcase
	endfunction

	function automatic void station_bounds(int g, output int lo, output int hi);
		int a, d, m;
		a = clamp_ent(sh_add);
		d = clamp_ent(a + sh_div);
		m = clamp_ent(d + sh_mem);
		case (g)
			0: begin lo = 0; hi = a; end
			1: begin lo = a; hi = d; end
			default: begin lo = d; hi = m; end
		endcase
	endfunction

	function automatic int group_of_entry(int e);
		int lo, hi;
		if (sh_mode)
			return ent_op[e];
		for (int g = 0; g < NG; g++) begin
			station_bounds(g, lo, hi);
			if (e >= lo && e < hi)
				return g;
		end
		return NG;
	endfunction

	function automatic bit reg_ok(logic [6:0] r);
		int lim;
		lim = (sh_regs > NREG) ? NREG : sh_regs;
		return r >= 1 && r <= lim;
	endfunction

	function automatic void shadow_reset();
		sh_mode = 0; sh_uni = 0; sh_add = 0; sh_div = 0; sh_mem = 0; sh_regs = 64;
		for (int e = 0; e < NENT; e++) begin
			ent_busy[e] = 0; ent_exec[e] = 0; ent_op[e] = OP_ADD;
			ent_tag_a[e] = 0; ent_tag_b[e] = 0; ent_rdy_a[e] = 0; ent_rdy_b[e] = 0;
			ent_issued_at[e] = 0; ent_started_at[e] = 0;
		end
		for (int r = 0; r < NREG; r++)
			producer_of[r] = 0;
		cyc = 1; n_issued = 0; n_retired = 0;
	endfunction

	function automatic void shadow_write(logic [2:0] idx, logic [6:0] v);
		case (idx)
			CFG_RS_MODE:   sh_mode = v[0];
			CFG_UNIFIED:   sh_uni = v[5:0];
			CFG_ADD:       sh_add = v[5:0];
			CFG_DIV:       sh_div = v[5:0];
			CFG_MEM:       sh_mem = v[5:0];
			CFG_REG_COUNT: sh_regs = v;
			default: ;
		endcase
	endfunction

	function automatic bit place_issue(logic [1:0] op, logic [6:0] d, logic [6:0] a,
			logic [6:0] b);
		int lo, hi;
		if (op > OP_MEM)
			return 0;
		if (sh_mode) begin
			lo = 0; hi = clamp_ent(sh_uni);
		end else
			station_bounds(op, lo, hi);
		for (int e = lo; e < hi; e++) begin
			if (ent_busy[e])
				continue;
			ent_busy[e] = 1; ent_exec[e] = 0; ent_op[e] = op;
			ent_tag_a[e] = 0; ent_rdy_a[e] = 1;
			if (reg_ok(a) && producer_of[a-1] != 0) begin
				ent_tag_a[e] = producer_of[a-1]; ent_rdy_a[e] = 0;
			end
			ent_tag_b[e] = 0; ent_rdy_b[e] = 1;
			if (reg_ok(b) && producer_of[b-1] != 0) begin
				ent_tag_b[e] = producer_of[b-1]; ent_rdy_b[e] = 0;
			end
			ent_issued_at[e] = cyc;
			ent_started_at[e] = 0;
			if (reg_ok(d))
				producer_of[d-1] = e + 1;
			n_issued++;
			return 1;
		end
		return 0;
	endfunction

	function automatic sched_result_t schedule_step(logic rt, logic [1:0] op,
			logic [6:0] d, logic [6:0] a, logic [6:0] b);
		sched_result_t r;
		int pick [NG];
		int nfire, ndone, g;
		int cnt [NG];
		logic [5:0] tag;
		logic [31:0] due;
		r = '0;
		nfire = 0; ndone = 0;
		if (!rt)
			r.accepted = place_issue(op, d, a, b);
		else begin
			cyc = cyc + 1;
			for (int e = 0; e < NENT; e++) begin
				if (!ent_busy[e] || !ent_exec[e])
					continue;
				due = ent_started_at[e] + op_latency(ent_op[e]);
				if (due != cyc)
					continue;
				tag = e + 1;
				for (int k = 0; k < NENT; k++) begin
					if (!ent_busy[k])
						continue;
					if (!ent_rdy_a[k] && ent_tag_a[k] == tag) begin
						ent_rdy_a[k] = 1; ent_tag_a[k] = 0;
					end
					if (!ent_rdy_b[k] && ent_tag_b[k] == tag) begin
						ent_rdy_b[k] = 1; ent_tag_b[k] = 0;
					end
				end
				for (int k = 0; k < NREG; k++)
					if (producer_of[k] == tag)
						producer_of[k] = 0;
				ent_busy[e] = 0; ent_exec[e] = 0;
				n_retired++;
				ndone++;
			end
			for (int i = 0; i < NG; i++)
				pick[i] = -1;
			for (int e = 0; e < NENT; e++) begin
				if (!ent_busy[e] || ent_exec[e] || !ent_rdy_a[e] || !ent_rdy_b[e])
					continue;
				g = group_of_entry(e);
				if (g >= NG)
					continue;
				if (pick[g] < 0 || ent_issued_at[e] < ent_issued_at[pick[g]])
					pick[g] = e;
			end
			for (int i = 0; i < NG; i++) begin
				if (pick[i] < 0)
					continue;
				ent_exec[pick[i]] = 1;
				ent_started_at[pick[i]] = cyc;
				nfire++;
			end
		end
		for (int i = 0; i < NG; i++)
			cnt[i] = 0;
		for (int e = 0; e < NENT; e++)
			if (ent_busy[e] && ent_exec[e] && ent_op[e] <= OP_MEM)
				cnt[ent_op[e]]++;
		r.fired = nfire;
		r.completed = ndone;
		r.act_add = cnt[0];
		r.act_div = cnt[1];
		r.act_mem = cnt[2];
		r.drained = (n_issued == n_retired);
		return r;
	endfunction

	// one transaction on the request channel; predicts at acceptance
	task automatic send_req(logic rt, logic [1:0] op, logic [6:0] d, logic [6:0] a,
			logic [6:0] b, bit typed = 0, sched_result_t typed_res = '0);
		sched_result_t r;
		in_valid <= 1;
		req_type <= rt; op_kind <= op; dest_reg <= d; src_a_reg <= a; src_b_reg <= b;
		do @(posedge clk); while (!in_ready);
		r = schedule_step(rt, op, d, a, b);
		pending_results = {pending_results, (typed ? typed_res : r)};
		if (!no_idle && $urandom_range(99) < 31) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic quiesce();
		in_valid <= 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_regs(logic m, logic [6:0] u, logic [6:0] a, logic [6:0] d,
			logic [6:0] mm, logic [6:0] rc);
		logic [6:0] vals [6];
		logic [2:0] idx [6];
		vals = '{{6'd0, m}, u, a, d, mm, rc};
		idx = '{CFG_RS_MODE, CFG_UNIFIED, CFG_ADD, CFG_DIV, CFG_MEM, CFG_REG_COUNT};
		quiesce();
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			shadow_write(idx[i], vals[i]);
		end
		cfg_valid <= 0;
	endtask

	// ticks until the shadow reports every issued entry done, bounded since
	// entries stranded outside every station never fire
	task automatic drain_ticks();
		int n;
		n = 0;
		while (n_issued != n_retired && n < 60) begin
			send_req(1, OP_ADD, 7'd1, 7'd0, 7'd0);
			n++;
		end
	endtask

	function automatic logic [6:0] pick_reg(bit src);
		int lim;
		lim = (sh_regs == 0) ? 1 : ((sh_regs > 8) ? 8 : sh_regs);
		if ($urandom_range(99) < 12)
			return $urandom_range(127);
		return src ? $urandom_range(lim) : $urandom_range(1, lim);
	endfunction

	task automatic random_req();
		logic [1:0] op;
		if ($urandom_range(99) < 45) begin
			send_req(1, $urandom_range(3), $urandom_range(127), $urandom_range(127),
				$urandom_range(127));
		end else begin
			op = ($urandom_range(99) < 5) ? 2'd3 : $urandom_range(OP_MEM);
			send_req(0, op, pick_reg(0), pick_reg(1), pick_reg(1));
		end
	endtask

	stim_row_t dir_rows [] = '{
		// reset sizes are zero: every issue stalls, ticks see an empty station
		'{1'b0, OP_ADD, 7'd1, 7'd0, 7'd0, 1'b1, '{1'b0, 2'd0, 6'd0, 6'd0, 6'd0, 6'd0, 1'b1}},
		'{1'b1, OP_ADD, 7'd0, 7'd0, 7'd0, 1'b1, '{1'b0, 2'd0, 6'd0, 6'd0, 6'd0, 6'd0, 1'b1}},
		'{1'b0, 2'd3, 7'd127, 7'd127, 7'd127, 1'b1,
			'{1'b0, 2'd0, 6'd0, 6'd0, 6'd0, 6'd0, 1'b1}},
		// stations of four each from here
		'{1'b0, OP_ADD, 7'd1, 7'd0, 7'd0, 1'b0, '0},
		'{1'b0, OP_DIV, 7'd2, 7'd1, 7'd0, 1'b0, '0},
		'{1'b0, OP_MEM, 7'd3, 7'd2, 7'd1, 1'b0, '0},
		'{1'b0, OP_ADD, 7'd64, 7'd3, 7'd3, 1'b0, '0},
		'{1'b0, OP_ADD, 7'd0, 7'd64, 7'd0, 1'b0, '0},
		'{1'b0, OP_ADD, 7'd100, 7'd127, 7'd65, 1'b0, '0},
		'{1'b0, 2'd3, 7'd5, 7'd0, 7'd0, 1'b0, '0},
		'{1'b1, OP_ADD, 7'd0, 7'd0, 7'd0, 1'b0, '0},
		'{1'b0, OP_ADD, 7'd4, 7'd1, 7'd0, 1'b0, '0},
		'{1'b0, OP_ADD, 7'd5, 7'd0, 7'd0, 1'b0, '0},
		'{1'b1, OP_ADD, 7'd0, 7'd0, 7'd0, 1'b0, '0},
		'{1'b1, OP_MEM, 7'd127, 7'd127, 7'd127, 1'b0, '0},
		'{1'b0, OP_DIV, 7'd6, 7'd2, 7'd2, 1'b0, '0},
		'{1'b0, OP_DIV, 7'd7, 7'd0, 7'd0, 1'b0, '0},
		'{1'b0, OP_DIV, 7'd8, 7'd0, 7'd0, 1'b0, '0},
		'{1'b0, OP_DIV, 7'd9, 7'd0, 7'd0, 1'b0, '0},
		'{1'b1, OP_ADD, 7'd0, 7'd0, 7'd0, 1'b0, '0},
		'{1'b1, OP_ADD, 7'd0, 7'd0, 7'd0, 1'b0, '0},
		'{1'b1, OP_ADD, 7'd0, 7'd0, 7'd0, 1'b0, '0}
	};

	initial begin
		shadow_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			if (i == 3)
				write_regs(0, 7'd0, 7'd4, 7'd4, 7'd4, 7'd64);
			send_req(dir_rows[i].rt, dir_rows[i].op, dir_rows[i].dst, dir_rows[i].sa,
				dir_rows[i].sb, dir_rows[i].typed, dir_rows[i].res);
		end
		drain_ticks();
		for (int p = 0; p < 10; p++) begin
			case (p)
				0: write_regs(0, 7'd0, 7'd4, 7'd4, 7'd4, 7'd8);
				1: write_regs(1, 7'd32, 7'd0, 7'd0, 7'd0, 7'd64);
				2: write_regs(0, 7'd0, 7'd32, 7'd32, 7'd32, 7'd64);
				3: write_regs(1, 7'd127, 7'd3, 7'd2, 7'd1, 7'd127);
				4: write_regs(1, 7'd0, 7'd63, 7'd63, 7'd63, 7'd1);
				5: write_regs(0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0);
				default: write_regs($urandom_range(1), $urandom_range(127),
					$urandom_range(15), $urandom_range(15), $urandom_range(15),
					$urandom_range(127));
			endcase
			no_idle = (p == 6);
			for (int k = 0; k < 100; k++) begin
				if (p == 1 && k == 20)
					hold_req = 1;
				if (p == 3 && k == 60) begin
					in_valid <= 0;
					while (pending_results.size() != 0)
						@(posedge clk);
				end
				random_req();
			end
			// skip draining once so reconfiguration lands on busy entries
			if (p != 7)
				drain_ticks();
		end
		no_idle = 0;
		in_valid <= 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// result side: random back-pressure and one long hold-off
	initial begin
		int hold_left;
		sched_result_t want;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result transaction with nothing expected");
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (issue_accepted !== want.accepted) begin
						$error("issue_accepted exp %0d got %0d", want.accepted, issue_accepted);
						fail_count++;
					end
					if (fired_count !== want.fired) begin
						$error("fired_count exp %0d got %0d", want.fired, fired_count);
						fail_count++;
					end
					if (completed_count !== want.completed) begin
						$error("completed_count exp %0d got %0d", want.completed,
							completed_count);
						fail_count++;
					end
					if (active_add !== want.act_add) begin
						$error("active_add exp %0d got %0d", want.act_add, active_add);
						fail_count++;
					end
					if (active_div !== want.act_div) begin
						$error("active_div exp %0d got %0d", want.act_div, active_div);
						fail_count++;
					end
					if (active_mem !== want.act_mem) begin
						$error("active_mem exp %0d got %0d", want.act_mem, active_mem);
						fail_count++;
					end
					if (drained !== want.drained) begin
						$error("drained exp %0d got %0d", want.drained, drained);
						fail_count++;
					end
				end
			end
			if (hold_req) begin
				hold_req = 0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 0;
			end else
				out_ready <= no_idle || ($urandom_range(99) >= 31);
		end
	end

	initial begin
		#30_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
